/* src/brb_pkg.sv */
package brb_pkg;

  // Buffer sizing: one spare slot tells full from empty
  localparam int CAPACITY = 1023;
  localparam int SLOTS    = CAPACITY + 1;
  localparam int PTR_W    = $clog2(SLOTS);
  localparam int CNT_W    = 10;
  localparam int SUM_W    = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;

  // Item modes
  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_PEEK   = 2'd2;
  localparam logic [1:0] MODE_STATUS = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [7:0]       data_in;
    logic             first;
    logic             last;
    logic [CNT_W-1:0] length;
    logic [CNT_W-1:0] offset;
  } in_item_t;

  typedef struct packed {
    logic             ok;
    logic [7:0]       data_out;
    logic [CNT_W-1:0] used_count;
    logic [CNT_W-1:0] free_count;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;  // execute the accepted item
    logic load_data;  // capture memory read data into the result
  } brb_cmd_t;

  // Pointer advance modulo SLOTS; n never reaches SLOTS in use
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(p) + SUM_W'(n);
    if (sum >= SUM_W'(SLOTS)) begin
      sum = sum - SUM_W'(SLOTS);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Bytes held between head and tail
  function automatic logic [PTR_W-1:0] used_of(input logic [PTR_W-1:0] tail,
                                               input logic [PTR_W-1:0] head);
    logic [SUM_W-1:0] diff;
    if (tail >= head) begin
      diff = SUM_W'(tail) - SUM_W'(head);
    end else begin
      diff = SUM_W'(tail) + SUM_W'(SLOTS) - SUM_W'(head);
    end
    return diff[PTR_W-1:0];
  endfunction

endpackage

/* src/brb_ram.sv */
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* src/brb_ctrl.sv */
module brb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output brb_pkg::brb_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       load_item;

  // Take a new item when no result is pending or the pending one leaves now
  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_RESP) && out_ready);
  assign load_item = in_valid && in_ready;
  assign out_valid = (state_r == S_RESP);

  assign cmd.load_item = load_item;
  assign cmd.load_data = (state_r == S_READ);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (load_item) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (load_item) state_nxt = S_READ;
        else if (out_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An accepted item always reaches the read slot next
  a_item_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    load_item |=> (state_r == S_READ))
    else $error("accepted item did not enter read state");

  // Read data is captured in the read state, which always leads to a presented result
  a_read_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> out_valid)
    else $error("result not presented after read");

  // No item is taken while a read is in flight
  a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !in_ready)
    else $error("input ready during read");

endmodule

/* src/brb_dp.sv */
module brb_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  brb_pkg::brb_cmd_t  cmd,
  input  brb_pkg::in_item_t  item,
  output brb_pkg::out_item_t result
);

  logic [brb_pkg::PTR_W-1:0] head_r, head_nxt;
  logic [brb_pkg::PTR_W-1:0] tail_r, tail_nxt;
  logic [brb_pkg::PTR_W-1:0] pend_r, pend_nxt;
  logic [brb_pkg::CNT_W-1:0] rem_r, rem_nxt;
  logic                      rej_r, rej_nxt;
  logic                      peek_ok_r;
  brb_pkg::out_item_t        res_r;

  logic [brb_pkg::PTR_W-1:0] used_now;
  logic [brb_pkg::PTR_W-1:0] free_now;
  logic [brb_pkg::PTR_W-1:0] used_after;
  logic [brb_pkg::PTR_W-1:0] pend_run;
  logic [brb_pkg::PTR_W-1:0] rd_addr;
  logic [7:0]                rd_data;
  logic                      ok;
  logic                      take;
  logic                      peek_ok;
  logic                      wr_en;

  assign used_now = brb_pkg::used_of(tail_r, head_r);
  assign free_now = brb_pkg::PTR_W'(brb_pkg::CAPACITY) - used_now;

  // Item execution: pointer and run bookkeeping
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    pend_nxt = pend_r;
    rem_nxt  = rem_r;
    rej_nxt  = rej_r;
    pend_run = pend_r;
    ok       = 1'b0;
    take     = 1'b0;
    peek_ok  = 1'b0;
    unique case (item.mode)
      brb_pkg::MODE_PUSH: begin
        if (item.first) begin
          pend_run = tail_r;
          if (brb_pkg::SUM_W'(item.length) > brb_pkg::SUM_W'(free_now)) begin
            rej_nxt = 1'b1;
            rem_nxt = '0;
          end else begin
            rej_nxt = 1'b0;
            rem_nxt = item.length;
            ok      = 1'b1;
            take    = (item.length != '0);
          end
        end else if (!rej_r && (rem_r != '0)) begin
          take = 1'b1;
          ok   = 1'b1;
        end
        pend_nxt = pend_run;
        if (take) begin
          pend_nxt = brb_pkg::ring_add(pend_run, brb_pkg::CNT_W'(1));
          rem_nxt  = rem_nxt - brb_pkg::CNT_W'(1);
        end
        // Last byte commits the run unless it was refused
        if (item.last) begin
          if (!rej_nxt) tail_nxt = pend_nxt;
          pend_nxt = rej_nxt ? tail_r : pend_nxt;
          rem_nxt  = '0;
          rej_nxt  = 1'b0;
        end
      end
      brb_pkg::MODE_POP: begin
        if (brb_pkg::SUM_W'(item.length) <= brb_pkg::SUM_W'(used_now)) begin
          head_nxt = brb_pkg::ring_add(head_r, item.length);
          ok       = 1'b1;
        end
      end
      brb_pkg::MODE_PEEK: begin
        if (brb_pkg::SUM_W'(item.offset) < brb_pkg::SUM_W'(used_now)) begin
          peek_ok = 1'b1;
          ok      = 1'b1;
        end
      end
      brb_pkg::MODE_STATUS: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign used_after = brb_pkg::used_of(tail_nxt, head_nxt);
  assign rd_addr    = brb_pkg::ring_add(head_r, item.offset);
  assign wr_en      = cmd.load_item && take;

  // Byte store
  brb_ram #(
    .WIDTH(8),
    .DEPTH(brb_pkg::SLOTS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(pend_run),
    .wr_data(item.data_in),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      pend_r <= '0;
      rem_r  <= '0;
      rej_r  <= 1'b0;
    end else if (cmd.load_item) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      pend_r <= pend_nxt;
      rem_r  <= rem_nxt;
      rej_r  <= rej_nxt;
    end
  end

  // Result register; the peeked byte is loaded in the read state that follows
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      peek_ok_r        <= peek_ok;
      res_r.ok         <= ok;
      res_r.data_out   <= '0;
      res_r.used_count <= brb_pkg::CNT_W'(used_after);
      res_r.free_count <= brb_pkg::CNT_W'(brb_pkg::PTR_W'(brb_pkg::CAPACITY) - used_after);
    end else if (cmd.load_data) begin
      res_r.data_out <= peek_ok_r ? rd_data : 8'd0;
    end
  end

  assign result = res_r;

endmodule

/* src/byte_ring_buffer_unit.sv */
// Byte ring buffer: a byte FIFO holding up to 1023 bytes (1024 slots).
// Input channel (in_valid/in_ready/in_data) carries one command item:
//   push a byte (runs marked first/last, first declares the run length),
//   pop a count of bytes, peek the byte at an offset from the head,
//   or just report status. Each item yields exactly one result item on
//   the output channel (out_valid/out_ready/out_data) with ok, the peeked
//   byte and the committed used/free counts after that item.
// Sequence: an accepted item passes through a read state before its result
//   is offered; the store has a registered read port, so that state goes
//   to the read.
// Overlap: no item is taken while a read is in flight; a new item is
//   accepted in the same cycle a result is taken.
// Stall: while a result is offered and out_ready is low, the result is held
//   in the output register and in_ready stays low.
// Reset (rst_n low, synchronous): pointers, run state and the controller
//   clear; the buffer reads empty. Store contents are not cleared, so no
//   clearing pass is needed and items are taken the cycle after reset.
module byte_ring_buffer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  brb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output brb_pkg::out_item_t out_data
);

  brb_pkg::brb_cmd_t cmd;

  brb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  brb_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .item  (in_data),
    .result(out_data)
  );

endmodule
